// ===== sv/isdg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdg_pkg
// shared types and constants of the inverse-square density gradient block
// ----------------------------------------------------------------------------
package isdg_pkg;

    localparam int POS_FRAC_BITS = 24;
    // numerator shifts above the 32 quotient bits that the divider produces
    localparam int DEN_SHIFT     = 2 * POS_FRAC_BITS - 32;
    localparam int GRD_SHIFT     = 3 * POS_FRAC_BITS - 32;

    localparam int DIV_W         = 128;
    localparam int QUO_W         = 32;
    localparam int STEP_W        = 31;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int NCOMP         = 3;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ORIGIN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_DENSITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_STEP    = 1'd1;

    localparam logic [31:0]       SURFACE_DENSITY_RST = 32'd65536;
    localparam logic [STEP_W-1:0] DEFAULT_STEP_RST    = 31'd167772;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0]          density;
        logic signed [31:0]   grad_x;
        logic signed [31:0]   grad_y;
        logic signed [31:0]   grad_z;
        logic [STEP_W-1:0]    step_len;
        logic [STATUS_W-1:0]  status;
        logic                 last_out;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          wdata;
    } t_cfg_item;

    // flags that ride along the divider stages
    typedef struct packed {
        logic             origin;
        logic             last;
        logic [NCOMP-1:0] pos_neg;
        logic [NCOMP:0]   ovf;
    } t_side;

endpackage

// ===== sv/isdg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdg_if
// valid/ready channels of the inverse-square density gradient block
// ----------------------------------------------------------------------------
interface isdg_in_if;
    import isdg_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface isdg_out_if;
    import isdg_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface isdg_cfg_if;
    import isdg_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/isdg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdg_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module isdg_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [isdg_pkg::DIV_W-1:0] i_num,
    input  logic [isdg_pkg::DIV_W-1:0] i_den,
    output logic [isdg_pkg::QUO_W-1:0] o_quo
);
    import isdg_pkg::*;

    // i_num must stay below i_den; the low numerator bits shifted in are zero
    logic [DIV_W-1:0] r_rem [QUO_W];
    logic [DIV_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DIV_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];
    logic [DIV_W-1:0] s_rem [QUO_W];
    logic [DIV_W-1:0] s_den [QUO_W];
    logic [QUO_W-1:0] s_quo [QUO_W];

    assign s_rem[0] = i_num;
    assign s_den[0] = i_den;
    assign s_quo[0] = '0;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DIV_W:0] trial;
        logic           take;
        if (k > 0) begin : g_link
            assign s_rem[k] = r_rem[k-1];
            assign s_den[k] = r_den[k-1];
            assign s_quo[k] = r_quo[k-1];
        end
        assign trial    = {s_rem[k], 1'b0} - {1'b0, s_den[k]};
        assign take     = !trial[DIV_W];
        assign n_rem[k] = take ? trial[DIV_W-1:0] : {s_rem[k][DIV_W-2:0], 1'b0};
        assign n_quo[k] = {s_quo[k][QUO_W-2:0], take};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= s_den[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== sv/inverse_square_density_gradient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_square_density_gradient
// inverse-square plasma density and its gradient for one ray position
// ----------------------------------------------------------------------------
// channel  | dir | payload                                      | handshake
// i_in     | in  | pos_x, pos_y, pos_z (Q8.24), is_last         | valid/ready
// o_out    | out | density, grad_x/y/z (Q16.16), step_len, ...  | valid/ready
// i_cfg    | in  | idx (0 surface_density, 1 default_step), data| valid/ready
//
// one ray enters every cycle while the output is not stalled; the 32 stage
// restoring dividers (one quotient bit per stage) sit behind 6 multiply/add stages
// i_rst_n is synchronous: valid bits clear, configuration registers return to defaults
// the whole pipe freezes while the output register holds an untaken result;
// a bubble never blocks input while the output is empty or being taken
// ----------------------------------------------------------------------------
module inverse_square_density_gradient (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isdg_in_if.sink     i_in,
    isdg_out_if.source  o_out,
    isdg_cfg_if.sink    i_cfg
);
    import isdg_pkg::*;

    // configuration registers
    logic [31:0]       r_surface_density;
    logic [STEP_W-1:0] r_default_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_density <= SURFACE_DENSITY_RST;
            r_default_step    <= DEFAULT_STEP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.idx)
                REG_SURFACE_DENSITY: r_surface_density <= i_cfg.data.wdata;
                REG_DEFAULT_STEP:    r_default_step    <= i_cfg.data.wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // global advance: the pipe moves unless a finished result is waiting
    logic w_adv;
    logic r_v_out;
    assign w_adv      = !r_v_out || o_out.ready;
    assign i_in.ready = w_adv;

    // stage 1: magnitudes and signs
    logic              r_v1;
    logic [31:0]       r1_mag [NCOMP];
    logic [NCOMP-1:0]  r1_neg;
    logic              r1_last;
    logic [31:0]       w_raw  [NCOMP];

    assign w_raw[0] = i_in.data.pos_x;
    assign w_raw[1] = i_in.data.pos_y;
    assign w_raw[2] = i_in.data.pos_z;

    // stage 2: squares and density times magnitude
    logic              r_v2;
    logic [63:0]       r2_sq [NCOMP];
    logic [63:0]       r2_sm [NCOMP];
    logic [NCOMP-1:0]  r2_neg;
    logic              r2_last;

    // stage 3: r squared, shifted numerators
    logic              r_v3;
    logic [63:0]       r3_r2;
    logic [DIV_W-1:0]  r3_gn [NCOMP];
    logic [DIV_W-1:0]  r3_dn;
    logic [NCOMP-1:0]  r3_neg;
    logic              r3_last;

    // stage 4: partial products of r^4
    logic              r_v4;
    logic [63:0]       r4_r2;
    logic [63:0]       r4_ll;
    logic [63:0]       r4_hl;
    logic [63:0]       r4_hh;
    logic [DIV_W-1:0]  r4_gn [NCOMP];
    logic [DIV_W-1:0]  r4_dn;
    logic [NCOMP-1:0]  r4_neg;
    logic              r4_last;

    // stage 5: r^4 assembled
    logic              r_v5;
    logic [63:0]       r5_r2;
    logic [DIV_W-1:0]  r5_d2;
    logic [DIV_W-1:0]  r5_gn [NCOMP];
    logic [DIV_W-1:0]  r5_dn;
    logic [NCOMP-1:0]  r5_neg;
    logic              r5_last;

    // stage 6: overflow checks, divider operands
    logic              r_v6;
    logic [DIV_W-1:0]  r6_den_r2;
    logic [DIV_W-1:0]  r6_d2;
    logic [DIV_W-1:0]  r6_gn [NCOMP];
    logic [DIV_W-1:0]  r6_dn;
    t_side             r6_side;
    t_side             n6_side;
    logic [DIV_W-1:0]  w5_r2w;

    assign w5_r2w = DIV_W'(r5_r2);

    always_comb begin
        n6_side.origin  = (r5_r2 == 64'd0);
        n6_side.last    = r5_last;
        n6_side.pos_neg = r5_neg;
        // quotient would need more than 32 bits
        n6_side.ovf[0]  = (r5_dn >= w5_r2w);
        for (int c = 0; c < NCOMP; c++) begin
            n6_side.ovf[c+1] = (r5_gn[c] >= r5_d2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < NCOMP; c++) begin
                r1_neg[c] <= w_raw[c][31];
                r1_mag[c] <= w_raw[c][31] ? (32'd0 - w_raw[c]) : w_raw[c];
            end
            r1_last <= i_in.data.is_last;

            for (int c = 0; c < NCOMP; c++) begin
                r2_sq[c] <= 64'(r1_mag[c]) * 64'(r1_mag[c]);
                r2_sm[c] <= 64'(r_surface_density) * 64'(r1_mag[c]);
            end
            r2_neg  <= r1_neg;
            r2_last <= r1_last;

            r3_r2 <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            for (int c = 0; c < NCOMP; c++) begin
                // 2 * S * |p| scaled by 2^(3F-32)
                r3_gn[c] <= DIV_W'(r2_sm[c]) << (GRD_SHIFT + 1);
            end
            r3_dn   <= DIV_W'(r_surface_density) << DEN_SHIFT;
            r3_neg  <= r2_neg;
            r3_last <= r2_last;

            r4_r2   <= r3_r2;
            r4_ll   <= 64'(r3_r2[31:0])  * 64'(r3_r2[31:0]);
            r4_hl   <= 64'(r3_r2[63:32]) * 64'(r3_r2[31:0]);
            r4_hh   <= 64'(r3_r2[63:32]) * 64'(r3_r2[63:32]);
            r4_gn   <= r3_gn;
            r4_dn   <= r3_dn;
            r4_neg  <= r3_neg;
            r4_last <= r3_last;

            r5_r2   <= r4_r2;
            r5_d2   <= {r4_hh, 64'd0} + {31'd0, r4_hl, 33'd0} + {64'd0, r4_ll};
            r5_gn   <= r4_gn;
            r5_dn   <= r4_dn;
            r5_neg  <= r4_neg;
            r5_last <= r4_last;

            // an overflowing numerator is replaced by zero to keep the divider in range
            r6_den_r2 <= w5_r2w;
            r6_d2     <= r5_d2;
            r6_dn     <= n6_side.ovf[0] ? '0 : r5_dn;
            for (int c = 0; c < NCOMP; c++) begin
                r6_gn[c] <= n6_side.ovf[c+1] ? '0 : r5_gn[c];
            end
            r6_side <= n6_side;
        end
    end

    // dividers: density and the three gradient magnitudes
    logic [QUO_W-1:0] w_q_den;
    logic [QUO_W-1:0] w_q_grd [NCOMP];

    isdg_div u_div_den (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r6_dn),
        .i_den (r6_den_r2),
        .o_quo (w_q_den)
    );

    for (genvar c = 0; c < NCOMP; c++) begin : g_grd
        isdg_div u_div_grd (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r6_gn[c]),
            .i_den (r6_d2),
            .o_quo (w_q_grd[c])
        );
    end

    // flags travel beside the divider stages
    logic  r_sv [QUO_W];
    t_side r_sb [QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_sv[0] <= r_v6;
            for (int k = 1; k < QUO_W; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb[0] <= r6_side;
            for (int k = 1; k < QUO_W; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // final saturation, sign and status
    t_out_item  n_out;
    t_out_item  r_out;
    t_side      w_sd;
    logic [31:0] w_grd [NCOMP];
    logic [NCOMP:0] w_sat;

    assign w_sd = r_sb[QUO_W-1];

    always_comb begin
        logic [31:0] lim;
        logic [31:0] mag;
        logic        rneg;
        w_sat[0] = w_sd.ovf[0];
        for (int c = 0; c < NCOMP; c++) begin
            // a positive coordinate gives a negative gradient
            rneg       = !w_sd.pos_neg[c];
            lim        = rneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            w_sat[c+1] = w_sd.ovf[c+1] || (w_q_grd[c] > lim);
            mag        = w_sat[c+1] ? lim : w_q_grd[c];
            w_grd[c]   = rneg ? (32'd0 - mag) : mag;
        end

        n_out.step_len = r_default_step;
        n_out.last_out = w_sd.last;
        if (w_sd.origin) begin
            n_out.density = '0;
            n_out.grad_x  = '0;
            n_out.grad_y  = '0;
            n_out.grad_z  = '0;
            n_out.status  = STATUS_ORIGIN;
        end else begin
            n_out.density = w_sd.ovf[0] ? 32'hFFFF_FFFF : w_q_den;
            n_out.grad_x  = w_grd[0];
            n_out.grad_y  = w_grd[1];
            n_out.grad_z  = w_grd[2];
            n_out.status  = (|w_sat) ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_out <= 1'b0;
        end else if (w_adv) begin
            r_v_out <= r_sv[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_v_out;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_origin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.status == STATUS_ORIGIN |->
            o_out.data.density == 32'd0 && o_out.data.grad_x == 32'sd0 &&
            o_out.data.grad_y == 32'sd0 && o_out.data.grad_z == 32'sd0)
        else $error("origin result carries nonzero values");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.status == STATUS_OK ||
            o_out.data.status == STATUS_SAT || o_out.data.status == STATUS_ORIGIN)
        else $error("reserved status code");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule
